FILE: hdl/sstf_pkg.sv
// Shared constants, widths and types of the shortest-seek-first request scheduler.
package sstf_pkg;

  localparam int MAX_REQUESTS = 64;
  localparam int TRACK_BITS   = 16;

  localparam int IDX_BITS  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_BITS  = $clog2(MAX_REQUESTS + 1);
  localparam int LEAVES    = 1 << IDX_BITS;
  localparam int TREE_LAT  = IDX_BITS + 1;
  localparam int WAIT_BITS = $clog2(TREE_LAT + 1);

  localparam int IN_TRACK_W  = 16;
  localparam int OUT_TRACK_W = 16;
  localparam int DIST_W      = 16;
  localparam int TOTAL_W     = 22;
  localparam int OUT_DATA_W  = 56;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_TRACK_W - DIST_W - TOTAL_W;
  localparam int SUM_W       = ((TRACK_BITS > TOTAL_W) ? TRACK_BITS : TOTAL_W) + 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic                  vld;
    logic                  up;
    logic [TRACK_BITS-1:0] span;
    logic [IDX_BITS-1:0]   idx;
  } node_t;

  typedef struct packed {
    logic load;
    logic start;
    logic serve;
  } cmd_t;

  typedef struct packed {
    logic last_one;
    logic out_busy;
  } sts_t;

endpackage

FILE: hdl/sstf_tree.sv
// Registered nearest-distance comparison tree over all request lanes.
module sstf_tree
  import sstf_pkg::*;
(
  input  logic                  clk,
  input  logic [TRACK_BITS-1:0] head,
  input  logic [TRACK_BITS-1:0] tracks [MAX_REQUESTS],
  input  logic [MAX_REQUESTS-1:0] pending,
  output node_t                 root
);

  node_t tree [2*LEAVES-1];

  function automatic node_t pick(input node_t l, input node_t r);
    node_t res;
    if (r.vld && (!l.vld || (r.span < l.span))) begin
      res = r;
    end else begin
      res = l;
    end
    return res;
  endfunction

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < MAX_REQUESTS) begin : g_live
      always_ff @(posedge clk) begin
        tree[LEAVES-1+i].vld  <= pending[i];
        tree[LEAVES-1+i].up   <= tracks[i] >= head;
        tree[LEAVES-1+i].span <= (tracks[i] >= head) ? tracks[i] - head : head - tracks[i];
        tree[LEAVES-1+i].idx  <= IDX_BITS'(i);
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        tree[LEAVES-1+i] <= '0;
      end
    end
  end

  for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
    always_ff @(posedge clk) begin
      tree[k] <= pick(tree[2*k+1], tree[2*k+2]);
    end
  end

  assign root = tree[0];

endmodule

FILE: hdl/sstf_datapath.sv
// Request store, pending flags, head and total registers, and the result register.
module sstf_datapath
  import sstf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [IN_TRACK_W-1:0] s_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IN_TRACK_W-1:0] cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  logic [TRACK_BITS-1:0]   store [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] pending;
  logic [CNT_BITS-1:0]     load_count;
  logic [CNT_BITS-1:0]     remaining;
  logic [IN_TRACK_W-1:0]   initial_head;
  logic [TRACK_BITS-1:0]   head;
  logic [TRACK_BITS-1:0]   head_next;
  logic [TOTAL_W-1:0]      total;
  logic [TOTAL_W-1:0]      total_next;
  logic [SUM_W-1:0]        sum;
  logic                    dropped;
  logic                    full;
  node_t                   root;

  sstf_tree u_tree (
    .clk     (clk),
    .head    (head),
    .tracks  (store),
    .pending (pending),
    .root    (root)
  );

  assign cfg_ready    = 1'b1;
  assign full         = load_count == CNT_BITS'(MAX_REQUESTS);
  assign sts.last_one = remaining == CNT_BITS'(1);
  assign sts.out_busy = m_tvalid && !m_tready;

  always_comb begin
    head_next  = root.up ? head + root.span : head - root.span;
    sum        = SUM_W'(total) + SUM_W'(root.span);
    total_next = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      store[load_count[IDX_BITS-1:0]] <= TRACK_BITS'(s_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_head <= '0;
    end else if (cfg_valid && cfg_ready) begin
      initial_head <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      load_count <= '0;
      remaining  <= '0;
      dropped    <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          pending[load_count[IDX_BITS-1:0]] <= 1'b1;
          load_count <= load_count + CNT_BITS'(1);
        end
      end
      if (cmd.start) begin
        remaining <= full ? load_count : load_count + CNT_BITS'(1);
      end
      if (cmd.serve) begin
        pending[root.idx] <= 1'b0;
        remaining <= remaining - CNT_BITS'(1);
        if (sts.last_one) begin
          load_count <= '0;
          dropped    <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      head  <= TRACK_BITS'(initial_head);
      total <= '0;
    end else if (cmd.serve) begin
      head  <= head_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.serve) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.serve) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, total_next, DIST_W'(root.span), OUT_TRACK_W'(head_next)};
      m_tlast <= sts.last_one;
      m_tuser <= dropped;
    end
  end

`ifndef SYNTHESIS
  a_serve_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.serve |-> root.vld)
    else $error("served a request with no pending lane");

  a_served_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.serve |=> !pending[$past(root.idx)])
    else $error("served request still pending");

  a_batch_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.serve && sts.last_one |=> load_count == '0 && pending == '0)
    else $error("batch state not cleared after final result");

  a_no_load_in_search: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.serve))
    else $error("load and serve in the same cycle");
`endif

endmodule

FILE: hdl/sstf_ctrl.sv
// Controller state machine that sequences loading and serving of a batch.
module sstf_ctrl
  import sstf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tlast,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_LOAD   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  state_t               state;
  logic [WAIT_BITS-1:0] wait_cnt;

  always_comb begin
    s_tready  = state == ST_LOAD;
    cmd.load  = s_tready && s_tvalid;
    cmd.start = cmd.load && s_tlast;
    cmd.serve = (state == ST_SEARCH) && (wait_cnt == '0) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      wait_cnt <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (cmd.start) begin
            state    <= ST_SEARCH;
            wait_cnt <= WAIT_BITS'(TREE_LAT);
          end
        end
        ST_SEARCH: begin
          if (wait_cnt != '0) begin
            wait_cnt <= wait_cnt - WAIT_BITS'(1);
          end else if (cmd.serve) begin
            if (sts.last_one) begin
              state <= ST_LOAD;
            end else begin
              wait_cnt <= WAIT_BITS'(TREE_LAT);
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

FILE: hdl/sstf_disk_request_scheduler.sv
// Requests load at one per cycle while s_tready is high, in the load state. Each result is
// set by the distance stage, the six-level registered comparison tree and the select cycle
// that moves the head; the next search waits for that move, and a stalled output holds it.
// Reset (synchronous, active high) clears the state machine, pending flags, counters and
// initial_head; the request store is not cleared and no clearing pass is needed.
module sstf_disk_request_scheduler
  import sstf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TRACK_W-1:0] s_tdata,   // [15:0] track
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] served_track, [31:16] seek_distance,
                                           // [53:32] total_seek, [55:54] zero
  output logic                  m_tlast,
  output logic                  m_tuser,   // [0] overflow
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IN_TRACK_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  sstf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sstf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
